### rtl/nat64amt_pkg.sv
// Shared types and constants of the NAT64 address mapping table.
package nat64amt_pkg;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [15:0] MAX_AGE_RESET = 16'd3000;

  localparam logic CFG_BASE_IP4 = 1'b0;
  localparam logic CFG_MAX_AGE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOOKUP6 = 2'd0,
    CMD_LOOKUP4 = 2'd1,
    CMD_CREATE  = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_HIT     = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_CREATED = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic issue;
    logic emit_hit;
    logic emit_miss;
    logic emit_create;
    logic emit_full;
    logic tick_step;
    logic tick_end;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e op;
    logic rd_vld;
    logic match;
    logic last;
    logic live_zero;
    logic pos_end;
    logic full;
  } dp_stat_t;

endpackage

### rtl/nat64amt_ctrl.sv
// Controller state machine that decodes each request and sequences the table scans of lookups and ticks.
module nat64amt_ctrl import nat64amt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic [1:0] command_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    logic finishing;
    finishing = 1'b0;
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (cmd_e'(command_i))
            CMD_CREATE: begin
              if (stat_i.full) begin
                cmd_o.emit_full = 1'b1;
              end else begin
                cmd_o.emit_create = 1'b1;
              end
            end
            CMD_TICK: begin
              if (!stat_i.live_zero) begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              if (stat_i.live_zero) begin
                cmd_o.emit_miss = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (stat_i.rd_vld) begin
          if (stat_i.op == CMD_TICK) begin
            cmd_o.tick_step = 1'b1;
            if (stat_i.last) begin
              cmd_o.tick_end = 1'b1;
              finishing      = 1'b1;
            end
          end else if (stat_i.match) begin
            cmd_o.emit_hit = 1'b1;
            finishing      = 1'b1;
          end else if (stat_i.last) begin
            cmd_o.emit_miss = 1'b1;
            finishing       = 1'b1;
          end
        end
        cmd_o.issue = !stat_i.pos_end && !finishing;
        if (finishing) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### rtl/nat64amt_dp.sv
// Datapath with the entry memories, scan counters, configuration and result registers.
module nat64amt_dp import nat64amt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  command_i,
  input  logic [63:0] ip6_high_i,
  input  logic [63:0] ip6_low_i,
  input  logic [31:0] ip4_key_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] mapped_ip4_o,
  output logic [63:0] mapped_ip6_high_o,
  output logic [63:0] mapped_ip6_low_o
);

  logic [63:0] mem_h   [ENTRIES];
  logic [63:0] mem_l   [ENTRIES];
  logic [31:0] mem_4   [ENTRIES];
  logic [15:0] mem_age [ENTRIES];

  logic [31:0] base_q;
  logic [15:0] max_age_q;
  cmd_e        op_q;
  logic [63:0] key_h_q, key_l_q;
  logic [31:0] key_4_q;
  logic [CNT_W-1:0] pos_q, kept_q, live_q;
  logic        rd_vld_q;
  logic [IDX_W-1:0] rd_pos_q;
  logic [63:0] rd_h_q, rd_l_q;
  logic [31:0] rd_4_q;
  logic [15:0] rd_age_q;
  logic        res_vld_q;
  logic [1:0]  res_stat_q;
  logic [31:0] res_4_q;
  logic [63:0] res_h_q, res_l_q;

  logic        match, keep, tick_keep;
  logic [7:0]  octet;
  logic [31:0] new_ip4;
  logic        we_data, we_age;
  logic [IDX_W-1:0] waddr, age_addr;
  logic [63:0] wd_h, wd_l;
  logic [31:0] wd_4;
  logic [15:0] wd_age;

  assign match = (op_q == CMD_LOOKUP6) ? (rd_h_q == key_h_q && rd_l_q == key_l_q)
                                       : (rd_4_q == key_4_q);
  assign keep      = (rd_age_q > 16'd1);
  assign tick_keep = cmd_i.tick_step && keep;
  assign octet     = base_q[7:0] + 8'(live_q) + 8'd1;
  assign new_ip4   = {base_q[31:8], octet};

  assign we_data  = cmd_i.emit_create || tick_keep;
  assign waddr    = cmd_i.emit_create ? live_q[IDX_W-1:0] : kept_q[IDX_W-1:0];
  assign wd_h     = cmd_i.emit_create ? ip6_high_i : rd_h_q;
  assign wd_l     = cmd_i.emit_create ? ip6_low_i : rd_l_q;
  assign wd_4     = cmd_i.emit_create ? new_ip4 : rd_4_q;
  assign we_age   = we_data || cmd_i.emit_hit;
  assign age_addr = cmd_i.emit_hit ? rd_pos_q : waddr;
  assign wd_age   = tick_keep ? rd_age_q - 16'd1 : max_age_q;

  always_ff @(posedge clk_i) begin
    if (we_data) begin
      mem_h[waddr] <= wd_h;
      mem_l[waddr] <= wd_l;
      mem_4[waddr] <= wd_4;
    end
    if (we_age) begin
      mem_age[age_addr] <= wd_age;
    end
    if (cmd_i.issue) begin
      rd_pos_q <= pos_q[IDX_W-1:0];
      rd_h_q   <= mem_h[pos_q[IDX_W-1:0]];
      rd_l_q   <= mem_l[pos_q[IDX_W-1:0]];
      rd_4_q   <= mem_4[pos_q[IDX_W-1:0]];
      rd_age_q <= mem_age[pos_q[IDX_W-1:0]];
    end
    if (cmd_i.load) begin
      key_h_q <= ip6_high_i;
      key_l_q <= ip6_low_i;
      key_4_q <= ip4_key_i;
    end
    res_stat_q <= STAT_MISS;
    res_4_q    <= '0;
    res_h_q    <= '0;
    res_l_q    <= '0;
    if (cmd_i.emit_hit) begin
      res_stat_q <= STAT_HIT;
      res_4_q    <= rd_4_q;
      res_h_q    <= rd_h_q;
      res_l_q    <= rd_l_q;
    end else if (cmd_i.emit_create) begin
      res_stat_q <= STAT_CREATED;
      res_4_q    <= new_ip4;
      res_h_q    <= ip6_high_i;
      res_l_q    <= ip6_low_i;
    end else if (cmd_i.emit_full) begin
      res_stat_q <= STAT_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      max_age_q <= MAX_AGE_RESET;
      op_q      <= CMD_LOOKUP6;
      pos_q     <= '0;
      kept_q    <= '0;
      live_q    <= '0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BASE_IP4: base_q    <= cfg_data_i;
          CFG_MAX_AGE:  max_age_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        op_q   <= cmd_e'(command_i);
        pos_q  <= '0;
        kept_q <= '0;
      end else begin
        if (cmd_i.issue) begin
          pos_q <= pos_q + CNT_W'(1);
        end
        if (tick_keep) begin
          kept_q <= kept_q + CNT_W'(1);
        end
      end
      if (cmd_i.emit_create) begin
        live_q <= live_q + CNT_W'(1);
      end else if (cmd_i.tick_end) begin
        live_q <= kept_q + CNT_W'(keep);
      end
      rd_vld_q  <= cmd_i.issue;
      res_vld_q <= cmd_i.emit_hit || cmd_i.emit_miss || cmd_i.emit_create || cmd_i.emit_full;
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.rd_vld    = rd_vld_q;
  assign stat_o.match     = match;
  assign stat_o.last      = ({1'b0, rd_pos_q} == live_q - CNT_W'(1));
  assign stat_o.live_zero = (live_q == '0);
  assign stat_o.pos_end   = (pos_q == live_q);
  assign stat_o.full      = (live_q == CNT_W'(ENTRIES));

  assign result_valid_o    = res_vld_q;
  assign status_o          = res_stat_q;
  assign mapped_ip4_o      = res_4_q;
  assign mapped_ip6_high_o = res_h_q;
  assign mapped_ip6_low_o  = res_l_q;

endmodule

### rtl/nat64_address_map_table.sv
// Top level of the NAT64 address mapping table with aging.
// A request is taken when start_i is high and busy_o is low. Create answers in the next
// cycle and never raises busy_o. A lookup or tick scans the live entries in insertion
// order through one registered read port, one entry per cycle; a lookup stops early at
// its first match. A tick gives no result. Each result is shown for one cycle under
// result_valid_o and cannot be held off by the receiver.
module nat64_address_map_table import nat64amt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] ip6_high_i,
  input  logic [63:0] ip6_low_i,
  input  logic [31:0] ip4_key_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] mapped_ip4_o,
  output logic [63:0] mapped_ip6_high_o,
  output logic [63:0] mapped_ip6_low_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  nat64amt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .busy_o    (busy_o)
  );

  nat64amt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .command_i         (command_i),
    .ip6_high_i        (ip6_high_i),
    .ip6_low_i         (ip6_low_i),
    .ip4_key_i         (ip4_key_i),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .mapped_ip4_o      (mapped_ip4_o),
    .mapped_ip6_high_o (mapped_ip6_high_o),
    .mapped_ip6_low_o  (mapped_ip6_low_o)
  );

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start_i && !busy_o) || $past(busy_o)))
    else $error("result without a pending request");

  a_tick_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_TICK) |=> !result_valid_o)
    else $error("tick produced a result");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == STAT_MISS || status_o == STAT_FULL)) |->
    (mapped_ip4_o == '0 && mapped_ip6_high_o == '0 && mapped_ip6_low_o == '0))
    else $error("miss or full result carries an address");

endmodule

### tb/tb_nat64_address_map_table.sv
// Self-checking testbench of the NAT64 address mapping table with aging.
module tb_nat64_address_map_table;
  import nat64amt_pkg::*;

  typedef struct {
    status_e     st;
    logic [31:0] ip4;
    logic [63:0] ip6_hi;
    logic [63:0] ip6_lo;
  } answer_t;

  class map_scoreboard;
    logic [31:0] base;
    logic [15:0] age_max;
    bit          used[ENTRIES];
    logic [63:0] key_hi[ENTRIES];
    logic [63:0] key_lo[ENTRIES];
    logic [31:0] addr4[ENTRIES];
    logic [15:0] age_left[ENTRIES];
    int          order[ENTRIES];
    int          live;
    answer_t     answer_q[$];
    int          errors;

    function new();
      base = '0;
      age_max = MAX_AGE_RESET;
      live = 0;
      errors = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void note_request(cmd_e c, logic [63:0] hi, logic [63:0] lo,
                               logic [31:0] k4);
      answer_t a;
      int s;
      int kept;
      logic [7:0] octet;
      a = '{STAT_MISS, '0, '0, '0};
      if (c == CMD_TICK) begin
        kept = 0;
        for (int p = 0; p < live; p++) begin
          s = order[p];
          if (age_left[s] <= 1) begin
            used[s] = 1'b0;
            age_left[s] = '0;
          end else begin
            age_left[s] = age_left[s] - 16'd1;
            order[kept] = s;
            kept++;
          end
        end
        live = kept;
        return;
      end
      if (c == CMD_CREATE) begin
        a.st = STAT_FULL;
        if (live < ENTRIES) begin
          for (s = 0; s < ENTRIES; s++) begin
            if (!used[s]) begin
              octet = base[7:0] + 8'(live) + 8'd1;
              used[s] = 1'b1;
              addr4[s] = {base[31:8], octet};
              key_hi[s] = hi;
              key_lo[s] = lo;
              age_left[s] = age_max;
              order[live] = s;
              live++;
              a = '{STAT_CREATED, addr4[s], hi, lo};
              break;
            end
          end
        end
      end else begin
        for (int p = 0; p < live; p++) begin
          s = order[p];
          if ((c == CMD_LOOKUP6) ? (key_hi[s] == hi && key_lo[s] == lo) : (addr4[s] == k4))
          begin
            age_left[s] = age_max;
            a = '{STAT_HIT, addr4[s], key_hi[s], key_lo[s]};
            break;
          end
        end
      end
      answer_q.push_back(a);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] ip4, logic [63:0] hi,
                               logic [63:0] lo);
      answer_t a;
      if (answer_q.size() == 0) begin
        $error("result with no request waiting: status %0d", st);
        errors++;
        return;
      end
      a = answer_q.pop_front();
      if (st !== a.st) begin
        $error("status: expected %0d, got %0d", a.st, st);
        errors++;
      end
      if (ip4 !== a.ip4) begin
        $error("mapped_ip4: expected %h, got %h", a.ip4, ip4);
        errors++;
      end
      if (hi !== a.ip6_hi) begin
        $error("mapped_ip6_high: expected %h, got %h", a.ip6_hi, hi);
        errors++;
      end
      if (lo !== a.ip6_lo) begin
        $error("mapped_ip6_low: expected %h, got %h", a.ip6_lo, lo);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = '0;
  logic [63:0] ip6_high_i = '0;
  logic [63:0] ip6_low_i = '0;
  logic [31:0] ip4_key_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [31:0] mapped_ip4_o;
  logic [63:0] mapped_ip6_high_o;
  logic [63:0] mapped_ip6_low_o;

  map_scoreboard sb = new();
  logic [63:0]   pool_hi[$];
  logic [63:0]   pool_lo[$];
  bit            idle_on = 1'b1;

  nat64_address_map_table u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result(status_o, mapped_ip4_o, mapped_ip6_high_o, mapped_ip6_low_o);
  end

  initial begin
    #20_000_000;
    $display("tb_nat64_address_map_table NOT OK");
    $finish;
  end

  task automatic send_request(cmd_e c, logic [63:0] hi, logic [63:0] lo, logic [31:0] k4);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(99) < 35) begin
        start_i = 1'b0;
      end else begin
        start_i = 1'b1;
        command_i = c;
        ip6_high_i = hi;
        ip6_low_i = lo;
        ip4_key_i = k4;
        break;
      end
    end
    do @(posedge clk_i); while (busy_o);
    sb.note_request(c, hi, lo, k4);
    if (c == CMD_CREATE) begin
      pool_hi.push_back(hi);
      pool_lo.push_back(lo);
      if (pool_hi.size() > 24) begin
        void'(pool_hi.pop_front());
        void'(pool_lo.pop_front());
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.answer_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] base, logic [15:0] age);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = CFG_BASE_IP4;
    cfg_data_i = base;
    @(negedge clk_i);
    cfg_idx_i = CFG_MAX_AGE;
    cfg_data_i = {16'h0, age};
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.base = base;
    sb.age_max = age;
  endtask

  task automatic random_request(logic [31:0] base);
    int          r;
    int          k;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] k4;
    r = $urandom_range(99);
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    k4 = ($urandom_range(1)) ? {base[31:8], 8'($urandom)} : $urandom;
    if (pool_hi.size() != 0 && $urandom_range(99) < 70) begin
      k = $urandom_range(pool_hi.size() - 1);
      hi = pool_hi[k];
      lo = pool_lo[k];
    end
    if (r < 30) send_request(CMD_LOOKUP6, hi, lo, k4);
    else if (r < 55) send_request(CMD_LOOKUP4, hi, lo, k4);
    else if (r < 85) send_request(CMD_CREATE, hi, lo, k4);
    else send_request(CMD_TICK, hi, lo, k4);
  endtask

  initial begin
    logic [31:0] bases[5];
    logic [15:0] ages[5];
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(CMD_LOOKUP6, '0, '0, '0);
    send_request(CMD_LOOKUP4, '1, '1, '1);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_CREATE, '0, '0, '0);
    send_request(CMD_CREATE, '1, '1, '0);
    send_request(CMD_CREATE, '0, '0, '0);
    send_request(CMD_LOOKUP6, '0, '0, '0);
    send_request(CMD_LOOKUP6, '1, '1, '0);
    send_request(CMD_LOOKUP4, '0, '0, 32'h0000_0002);
    send_request(CMD_LOOKUP4, '0, '0, 32'h0000_0003);
    send_request(CMD_TICK, '0, '0, '0);

    configure(32'hFFFF_FFFF, 16'd1);
    send_request(CMD_CREATE, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '0);
    send_request(CMD_CREATE, 64'h8000_0000_0000_0000, 64'h1, '0);
    send_request(CMD_LOOKUP4, '0, '0, 32'hFFFF_FF00);
    send_request(CMD_LOOKUP4, '0, '0, 32'hFFFF_FF01);
    send_request(CMD_LOOKUP6, 64'h8000_0000_0000_0000, 64'h1, '0);
    send_request(CMD_TICK, '0, '0, '0);
    send_request(CMD_LOOKUP6, 64'h8000_0000_0000_0000, 64'h1, '0);
    send_request(CMD_CREATE, '1, '0, '0);
    drain();

    bases = '{$urandom, 32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
    ages = '{16'($urandom_range(40, 2)), 16'hFFFF, 16'd1, 16'($urandom_range(12, 5)),
             16'($urandom_range(65535, 1))};
    foreach (bases[p]) begin
      configure(bases[p], ages[p]);
      idle_on = (p != 1);
      repeat (220) random_request(bases[p]);
    end
    idle_on = 1'b1;

    drain();
    if (sb.errors == 0)
      $display("tb_nat64_address_map_table OK");
    else
      $display("tb_nat64_address_map_table NOT OK");
    $finish;
  end
endmodule
